FILE: rtl/sbat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbat_pkg
// Shared types and constants for the segment bump allocator slot table.
// ----------------------------------------------------------------------------
package sbat_pkg;

	// table and memory geometry
	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = 3;
	localparam int PID_W     = 16;
	localparam int LEN_W     = 12;
	localparam int PTR_W     = 12;
	localparam int SUM_W     = 15;
	localparam logic [SUM_W-1:0] MEM_BYTES = SUM_W'(2048);

	// stream payload widths
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 40;

	// result codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_MEMORY = 2'd1,
		ST_NO_SLOT   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// request kinds
	typedef enum logic {
		CMD_CREATE    = 1'b0,
		CMD_TERMINATE = 1'b1
	} cmd_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/sbat_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbat_ctrl
// Request sequencer: takes one beat, then commits it once the result
// register can take the answer.
// ----------------------------------------------------------------------------
module sbat_ctrl
	import sbat_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t dp_status,
	output dp_cmd_t         dp_cmd
);

	state_t state_q;
	state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (dp_status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready        = 1'b0;
		dp_cmd.load_req = 1'b0;
		dp_cmd.commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				dp_cmd.load_req = s_tvalid;
			end
			ST_EXEC: begin
				dp_cmd.commit = dp_status.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/sbat_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbat_datapath
// Request register, slot table, bump pointer and result register.
// ----------------------------------------------------------------------------
module sbat_datapath
	import sbat_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd,
	input  wire logic [PID_W-1:0]    proc_id,
	input  wire logic [LEN_W-1:0]    code_len,
	input  wire logic [LEN_W-1:0]    heap_len,
	input  wire logic [LEN_W-1:0]    stack_len,
	input  wire dp_cmd_t             dp_cmd,
	output dp_status_t               dp_status,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output status_t                  status,
	output logic [SLOT_W-1:0]        slot_index,
	output logic [PTR_W-1:0]         code_start,
	output logic [PTR_W-1:0]         heap_start,
	output logic [PTR_W-1:0]         stack_start
);

	// request register
	cmd_t             cmd_q;
	logic [PID_W-1:0] pid_q;
	logic [LEN_W-1:0] code_q;
	logic [LEN_W-1:0] heap_q;
	logic [LEN_W-1:0] stack_q;

	// table state
	logic [NUM_SLOTS-1:0] active_q;
	logic [PID_W-1:0]     owner_q [NUM_SLOTS];
	logic [PTR_W-1:0]     free_ptr_q;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PTR_W-1:0]  code_base_q;
	logic [PTR_W-1:0]  heap_base_q;
	logic [PTR_W-1:0]  stack_base_q;

	// combinational results
	logic [SUM_W-1:0]  total;
	logic [SUM_W-1:0]  need;
	logic              mem_fail;
	logic              free_hit;
	logic [SLOT_W-1:0] free_slot;
	logic              match_hit;
	logic [SLOT_W-1:0] match_slot;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	logic              do_alloc;
	logic              do_clear;
	logic [PTR_W-1:0]  heap_base;
	logic [PTR_W-1:0]  stack_base;

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (dp_cmd.load_req) begin
			cmd_q   <= cmd_t'(cmd);
			pid_q   <= proc_id;
			code_q  <= code_len;
			heap_q  <= heap_len;
			stack_q <= stack_len;
		end
	end

	// memory check against the bump pointer
	always_comb begin
		total    = SUM_W'(code_q) + SUM_W'(heap_q) + SUM_W'(stack_q);
		need     = SUM_W'(free_ptr_q) + total;
		mem_fail = (need > MEM_BYTES);
	end

	// lowest free slot and lowest matching active slot
	always_comb begin
		free_hit   = 1'b0;
		free_slot  = '0;
		match_hit  = 1'b0;
		match_slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_hit  = 1'b1;
				free_slot = SLOT_W'(i);
			end
			if (active_q[i] && (owner_q[i] == pid_q)) begin
				match_hit  = 1'b1;
				match_slot = SLOT_W'(i);
			end
		end
	end

	// decide the outcome
	always_comb begin
		res_status = ST_OK;
		res_slot   = '0;
		do_alloc   = 1'b0;
		do_clear   = 1'b0;
		if (cmd_q == CMD_CREATE) begin
			priority if (mem_fail) begin
				res_status = ST_NO_MEMORY;
			end else if (!free_hit) begin
				res_status = ST_NO_SLOT;
			end else begin
				res_slot = free_slot;
				do_alloc = 1'b1;
			end
		end else begin
			if (match_hit) begin
				res_slot = match_slot;
				do_clear = 1'b1;
			end else begin
				res_status = ST_NOT_FOUND;
			end
		end
		heap_base  = free_ptr_q + code_q;
		stack_base = heap_base + heap_q;
	end

	// slot flags and bump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			free_ptr_q <= '0;
		end else if (dp_cmd.commit) begin
			if (do_alloc) begin
				active_q[res_slot] <= 1'b1;
				free_ptr_q         <= need[PTR_W-1:0];
			end
			if (do_clear) begin
				active_q[res_slot] <= 1'b0;
			end
		end
	end

	// owner pids
	always_ff @(posedge clk) begin
		if (dp_cmd.commit && do_alloc) begin
			owner_q[res_slot] <= pid_q;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			status_q     <= res_status;
			slot_q       <= res_slot;
			code_base_q  <= do_alloc ? free_ptr_q : '0;
			heap_base_q  <= do_alloc ? heap_base : '0;
			stack_base_q <= do_alloc ? stack_base : '0;
		end
	end

	assign dp_status.out_free = !out_valid_q || m_tready;
	assign m_tvalid    = out_valid_q;
	assign status      = status_q;
	assign slot_index  = slot_q;
	assign code_start  = code_base_q;
	assign heap_start  = heap_base_q;
	assign stack_start = stack_base_q;

endmodule

`default_nettype wire

FILE: rtl/segment_bump_allocator_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_bump_allocator_table_core
// Process slot table with a bump allocator for code, heap and stack segments.
// ----------------------------------------------------------------------------
//  channel  dir  tuser           tdata (lowest bit up)
//  s_*      in   cmd (1)         proc_id 16, code_len 12, heap_len 12,
//                                stack_len 12, zero fill 4
//  m_*      out  status (2)      slot_index 3, code_start 12, heap_start 12,
//                                stack_start 12, zero fill 1
//
//  Each request is first taken into the request register; then memory is
//  checked and the eight-entry slot table is searched and updated. The
//  result register frees the input side, so the next beat is taken while a
//  result waits; a request waits before its update only while the result
//  register is full and m_tready is low.
//  Reset clears the slot flags, the bump pointer and the result valid flag.
// ----------------------------------------------------------------------------
module segment_bump_allocator_table_core
	import sbat_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,   // proc_id, code_len, heap_len, stack_len
	input  wire logic                s_tuser,   // cmd
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // slot_index, code_start, heap_start, stack_start
	output logic [1:0]               m_tuser    // status
);

	dp_cmd_t           dp_cmd;
	dp_status_t        dp_status;
	status_t           status;
	logic [SLOT_W-1:0] slot_index;
	logic [PTR_W-1:0]  code_start;
	logic [PTR_W-1:0]  heap_start;
	logic [PTR_W-1:0]  stack_start;

	// request sequencer
	sbat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	// table and result datapath
	sbat_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (s_tuser),
		.proc_id     (s_tdata[15:0]),
		.code_len    (s_tdata[27:16]),
		.heap_len    (s_tdata[39:28]),
		.stack_len   (s_tdata[51:40]),
		.dp_cmd      (dp_cmd),
		.dp_status   (dp_status),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.status      (status),
		.slot_index  (slot_index),
		.code_start  (code_start),
		.heap_start  (heap_start),
		.stack_start (stack_start)
	);

	// pack the result beat
	assign m_tuser = status;
	assign m_tdata = {1'b0, stack_start, heap_start, code_start, slot_index};

endmodule

`default_nettype wire
